// ----- rtl/cbs_pkg.sv -----
// cbs_pkg: shared widths, register map, reset values and control structs
// for the cell balance top-n selector; no dependencies
package cbs_pkg;

	localparam int VOLT_W     = 16;
	localparam int IDX_W      = 6;
	localparam int MASK_W     = 16;
	localparam int MBIT_W     = $clog2(MASK_W);
	localparam int PERIOD_W   = 4;
	localparam int CTB_W      = 3;
	localparam int CFG_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DIFF_THR  = 2'd0;
	localparam logic [1:0] REG_MIN_FLOOR = 2'd1;
	localparam logic [1:0] REG_CELLS_BAL = 2'd2;
	localparam logic [1:0] REG_INTERVAL  = 2'd3;

	localparam logic [VOLT_W-1:0]   RST_DIFF_THR  = 16'd20;
	localparam logic [VOLT_W-1:0]   RST_MIN_FLOOR = 16'd3000;
	localparam logic [CTB_W-1:0]    RST_CELLS_BAL = 3'd2;
	localparam logic [PERIOD_W-1:0] RST_INTERVAL  = 4'd5;

	typedef struct packed {
		logic [VOLT_W-1:0]   diff_threshold;
		logic [VOLT_W-1:0]   min_cell_floor;
		logic [CTB_W-1:0]    cells_to_balance;
		logic [PERIOD_W-1:0] eval_interval;
	} cbs_cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
	} cbs_topn_ctrl_t;

endpackage

// ----- rtl/cbs_if.sv -----
// cbs_if: valid/ready channel interfaces for cell items and mask results
// depends on cbs_pkg
interface cbs_cell_if import cbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] cell_voltage;
	logic              last_cell;
	logic              sleep_mode;

	modport source (output valid, output cell_voltage, output last_cell, output sleep_mode,
		input ready);
	modport sink (input valid, input cell_voltage, input last_cell, input sleep_mode,
		output ready);
endinterface

interface cbs_mask_if import cbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] balance_mask;
	logic              forced_off;

	modport source (output valid, output balance_mask, output forced_off, input ready);
	modport sink (input valid, input balance_mask, input forced_off, output ready);
endinterface

// ----- rtl/cbs_regs.sv -----
// cbs_regs: apb configuration registers of the selector
// depends on cbs_pkg
module cbs_regs import cbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cbs_cfg_t              cfg
);
	cbs_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_threshold   <= RST_DIFF_THR;
			cfg_q.min_cell_floor   <= RST_MIN_FLOOR;
			cfg_q.cells_to_balance <= RST_CELLS_BAL;
			cfg_q.eval_interval    <= RST_INTERVAL;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DIFF_THR:  cfg_q.diff_threshold   <= pwdata[VOLT_W-1:0];
				REG_MIN_FLOOR: cfg_q.min_cell_floor   <= pwdata[VOLT_W-1:0];
				REG_CELLS_BAL: cfg_q.cells_to_balance <= pwdata[CTB_W-1:0];
				REG_INTERVAL:  cfg_q.eval_interval    <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIFF_THR:  prdata = APB_DATA_W'(cfg_q.diff_threshold);
			REG_MIN_FLOOR: prdata = APB_DATA_W'(cfg_q.min_cell_floor);
			REG_CELLS_BAL: prdata = APB_DATA_W'(cfg_q.cells_to_balance);
			REG_INTERVAL:  prdata = APB_DATA_W'(cfg_q.eval_interval);
			default:       prdata = '0;
		endcase
	end
endmodule

// ----- rtl/cbs_topn.sv -----
// cbs_topn: sorted top-n register set with scan minimum and cell position;
// insertion walks the slots one compare per cycle. depends on cbs_pkg
module cbs_topn import cbs_pkg::*; #(
	parameter int NUM_CELLS  = 16,
	parameter int MAX_SELECT = 4,
	parameter int CNT_W      = $clog2(MAX_SELECT + 1),
	parameter int SEL_W      = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbs_topn_ctrl_t    ctrl,
	input  logic [VOLT_W-1:0] din,
	input  logic [SEL_W-1:0]  rd_sel,
	output logic [VOLT_W-1:0] rd_value,
	output logic [IDX_W-1:0]  rd_index,
	output logic [VOLT_W-1:0] scan_min,
	output logic [CNT_W-1:0]  valid_cnt,
	output logic              done
);
	localparam int POS_W = $clog2(NUM_CELLS + 1);

	logic [VOLT_W-1:0] val_q [MAX_SELECT];
	logic [IDX_W-1:0]  idx_q [MAX_SELECT];
	logic [VOLT_W-1:0] min_q;
	logic [POS_W-1:0]  pos_q;
	logic [VOLT_W-1:0] v_q;
	logic [CNT_W-1:0]  j_q;
	logic              busy_q;
	logic              done_q;

	logic              room;
	logic              cmp_gt;
	logic              ins_en;
	logic [SEL_W-1:0]  ins_k;
	logic              finish;

	assign room      = 32'(pos_q) < 32'(NUM_CELLS);
	assign valid_cnt = (32'(pos_q) >= 32'(MAX_SELECT)) ? CNT_W'(MAX_SELECT) : CNT_W'(pos_q);
	assign rd_value  = val_q[rd_sel];
	assign rd_index  = idx_q[rd_sel];
	assign scan_min  = min_q;
	assign done      = done_q;

	// shared comparator: new voltage against the slot under test
	assign cmp_gt = v_q > val_q[j_q[SEL_W-1:0]];

	always_comb begin
		ins_en = 1'b0;
		ins_k  = j_q[SEL_W-1:0];
		finish = 1'b0;
		if (busy_q) begin
			if (j_q == valid_cnt) begin
				finish = 1'b1;
				if (32'(valid_cnt) < 32'(MAX_SELECT)) begin
					ins_en = 1'b1;
				end
			end else if (cmp_gt) begin
				finish = 1'b1;
				ins_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '1;
			pos_q  <= '0;
			v_q    <= '0;
			j_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.clear) begin
				min_q <= '1;
				pos_q <= '0;
			end else if (ctrl.start) begin
				if (room) begin
					v_q    <= din;
					j_q    <= '0;
					busy_q <= 1'b1;
					if (din < min_q) begin
						min_q <= din;
					end
				end else begin
					// cell beyond the pack size is ignored
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (finish) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					pos_q  <= POS_W'(pos_q + 1'b1);
				end else begin
					j_q <= CNT_W'(j_q + 1'b1);
				end
			end
		end
	end

	// slot 0 only takes the new value; higher slots shift down from above
	for (genvar g = 0; g < MAX_SELECT; g++) begin : g_slot
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (ins_en && ins_k == SEL_W'(0)) begin
					val_q[g] <= v_q;
					idx_q[g] <= IDX_W'(pos_q);
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (ins_en) begin
					if (32'(ins_k) == g) begin
						val_q[g] <= v_q;
						idx_q[g] <= IDX_W'(pos_q);
					end else if (32'(ins_k) < g) begin
						val_q[g] <= val_q[g-1];
						idx_q[g] <= idx_q[g-1];
					end
				end
			end
		end
	end
endmodule

// ----- rtl/cbs_eval.sv -----
// cbs_eval: builds the balance mask, one candidate per cycle through a
// single subtract and compare unit. depends on cbs_pkg
module cbs_eval import cbs_pkg::*; #(
	parameter int MAX_SELECT = 4,
	parameter int CNT_W      = $clog2(MAX_SELECT + 1),
	parameter int SEL_W      = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  n,
	input  cbs_cfg_t          cfg,
	input  logic [VOLT_W-1:0] scan_min,
	input  logic [VOLT_W-1:0] rd_value,
	input  logic [IDX_W-1:0]  rd_index,
	output logic [SEL_W-1:0]  rd_sel,
	output logic [MASK_W-1:0] mask,
	output logic              done
);
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  n_q;
	logic              busy_q;
	logic              done_q;
	logic              floor_ok_q;
	logic [MASK_W-1:0] mask_q;
	logic [VOLT_W-1:0] excess;
	logic              hit;

	assign rd_sel = j_q[SEL_W-1:0];
	assign mask   = mask_q;
	assign done   = done_q;

	// candidates never sit below the scan minimum
	assign excess = rd_value - scan_min;
	assign hit    = (excess > cfg.diff_threshold) && floor_ok_q &&
		(32'(rd_index) < 32'(MASK_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			n_q        <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			floor_ok_q <= 1'b0;
			mask_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				j_q        <= '0;
				n_q        <= n;
				busy_q     <= 1'b1;
				mask_q     <= '0;
				floor_ok_q <= scan_min >= cfg.min_cell_floor;
			end else if (busy_q) begin
				if (j_q == n_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (hit) begin
						mask_q <= mask_q | (MASK_W'(1) << rd_index[MBIT_W-1:0]);
					end
					j_q <= CNT_W'(j_q + 1'b1);
				end
			end
		end
	end
endmodule

// ----- rtl/cell_balance_top_n_select.sv -----
// cell_balance_top_n_select: passive balancing selector, top level
// depends on cbs_pkg, cbs_if, cbs_regs, cbs_topn, cbs_eval
//
// usage
// - cell_in takes one cell voltage per transfer in scan order; last_cell
//   closes the scan and sleep_mode is looked at only on that transfer
// - mask_out carries at most one result per closed scan: an all-off mask with
//   forced_off set when awake, or the evaluated mask on the scan where the
//   sleep period counter meets eval_interval (none when cells_to_balance is 0)
// - apb port writes the four registers at byte addresses 0, 4, 8 and 12
// timing
// - after a transfer, cell_in waits for the insertion of that cell:
//   the insertion walks the sorted slots one compare per cycle until it
//   finds its place, so the fill of the top-n set sets how long it takes
// - an evaluating scan then passes its n candidates through one subtract
//   and compare unit before the result reaches the output register
// - cell_in.ready is low while a cell, an evaluation or a delivery is worked on
// reset and stalls
// - reset clears the period counter, the scan minimum and the cell count
// - the output register holds a result until taken; a new cell is still
//   accepted then, and only a further result waits for the register to free
module cell_balance_top_n_select import cbs_pkg::*; #(
	parameter int NUM_CELLS  = 16,
	parameter int MAX_SELECT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cbs_cell_if.sink              cell_in,
	cbs_mask_if.source            mask_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int CNT_W = $clog2(MAX_SELECT + 1);
	localparam int SEL_W = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_INSERT  = 4'b0010,
		S_EVAL    = 4'b0100,
		S_DELIVER = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	cbs_cfg_t            cfg;
	cbs_topn_ctrl_t      topn_ctrl;

	logic                last_q;
	logic                sleep_q;
	logic [PERIOD_W-1:0] period_q;
	logic [MASK_W-1:0]   res_mask_q;
	logic                res_forced_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   out_mask_q;
	logic                out_forced_q;

	logic                accept;
	logic                ins_done;
	logic [VOLT_W-1:0]   scan_min;
	logic [CNT_W-1:0]    valid_cnt;
	logic [SEL_W-1:0]    rd_sel;
	logic [VOLT_W-1:0]   rd_value;
	logic [IDX_W-1:0]    rd_index;
	logic                eval_start;
	logic                eval_done;
	logic [MASK_W-1:0]   eval_mask;
	logic [CNT_W-1:0]    ctb_sat;
	logic [CNT_W-1:0]    eval_n;
	logic                eval_due;
	logic                scan_end;
	logic                deliver_load;

	cbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbs_topn #(
		.NUM_CELLS  (NUM_CELLS),
		.MAX_SELECT (MAX_SELECT),
		.CNT_W      (CNT_W),
		.SEL_W      (SEL_W)
	) u_topn (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (topn_ctrl),
		.din       (cell_in.cell_voltage),
		.rd_sel    (rd_sel),
		.rd_value  (rd_value),
		.rd_index  (rd_index),
		.scan_min  (scan_min),
		.valid_cnt (valid_cnt),
		.done      (ins_done)
	);

	cbs_eval #(
		.MAX_SELECT (MAX_SELECT),
		.CNT_W      (CNT_W),
		.SEL_W      (SEL_W)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eval_start),
		.n        (eval_n),
		.cfg      (cfg),
		.scan_min (scan_min),
		.rd_value (rd_value),
		.rd_index (rd_index),
		.rd_sel   (rd_sel),
		.mask     (eval_mask),
		.done     (eval_done)
	);

	// cells are taken only in the idle state, with no cell, evaluation or result in flight
	assign cell_in.ready = (state_q == S_IDLE);
	assign accept        = cell_in.valid & cell_in.ready;

	assign mask_out.valid        = out_valid_q;
	assign mask_out.balance_mask = out_mask_q;
	assign mask_out.forced_off   = out_forced_q;

	// candidate count: saturate at the slot count, then at the cells seen
	assign ctb_sat = (32'(cfg.cells_to_balance) > 32'(MAX_SELECT)) ?
		CNT_W'(MAX_SELECT) : CNT_W'(cfg.cells_to_balance);
	assign eval_n  = (ctb_sat > valid_cnt) ? valid_cnt : ctb_sat;

	assign eval_due     = sleep_q && (period_q == cfg.eval_interval);
	assign scan_end     = (state_q == S_INSERT) && ins_done && last_q;
	assign deliver_load = (state_q == S_DELIVER) && (!out_valid_q || mask_out.ready);

	// scan sequencer
	always_comb begin
		state_d         = state_q;
		topn_ctrl.start = accept;
		topn_ctrl.clear = 1'b0;
		eval_start      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				if (ins_done) begin
					if (!last_q) begin
						state_d = S_IDLE;
					end else if (!sleep_q) begin
						// awake: all-off result, scan state dropped
						topn_ctrl.clear = 1'b1;
						state_d         = S_DELIVER;
					end else if (eval_due && cfg.cells_to_balance != '0) begin
						eval_start = 1'b1;
						state_d    = S_EVAL;
					end else begin
						// asleep without a result
						topn_ctrl.clear = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			S_EVAL: begin
				if (eval_done) begin
					topn_ctrl.clear = 1'b1;
					state_d         = S_DELIVER;
				end
			end
			S_DELIVER: begin
				if (deliver_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_q       <= 1'b0;
			sleep_q      <= 1'b0;
			period_q     <= '0;
			out_valid_q  <= 1'b0;
			res_forced_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q  <= cell_in.last_cell;
				sleep_q <= cell_in.sleep_mode;
			end
			// period counter: cleared by an evaluation slot, then advanced
			if (scan_end && sleep_q) begin
				period_q <= eval_due ? PERIOD_W'(1) : PERIOD_W'(period_q + 1'b1);
			end
			if (scan_end && !sleep_q) begin
				res_forced_q <= 1'b1;
			end else if (eval_done) begin
				res_forced_q <= 1'b0;
			end
			if (deliver_load) begin
				out_valid_q <= 1'b1;
			end else if (mask_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (scan_end && !sleep_q) begin
			res_mask_q <= '0;
		end else if (eval_done) begin
			res_mask_q <= eval_mask;
		end
		if (deliver_load) begin
			out_mask_q   <= res_mask_q;
			out_forced_q <= res_forced_q;
		end
	end

	// a forced-off result never enables a resistor
	a_forced_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_forced_q |-> out_mask_q == '0)
		else $error("forced-off result with balancing enabled");

	// no more cells enabled than there are candidate slots
	a_mask_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones(out_mask_q) <= MAX_SELECT)
		else $error("balance mask enables more cells than slots");

	// an evaluation only starts on an evaluating sleep scan
	a_eval_on_due: assert property (@(posedge clk) disable iff (!arst_n)
		eval_start |-> scan_end && sleep_q && eval_due && eval_n != '0)
		else $error("evaluation started outside its slot");
endmodule

// ----- verif/tb_cell_balance_top_n_select.sv -----
// tb_cell_balance_top_n_select: self-checking bench for the cell balance top-n selector
// streams cell scans with random gaps, stalls the mask channel and predicts every mask
// depends on cbs_pkg, cbs_if and the cell_balance_top_n_select rtl
module tb_cell_balance_top_n_select;
	import cbs_pkg::*;

	localparam int NUM_CELLS      = 16;
	localparam int MAX_SEL        = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	// quiet cycles after the last mask, long enough for a cell insertion plus an evaluation
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 230;

	typedef struct packed {
		logic [VOLT_W-1:0] volt;
		logic              last;
		logic              sleep;
	} cell_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              forced_off;
	} mask_result_t;

	// how the voltages of one scan are spread
	typedef enum int {
		VOLT_SPREAD,
		VOLT_CLUSTER,
		VOLT_TIES,
		VOLT_EXTREME
	} volt_style_e;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cbs_cell_if cell_ch();
	cbs_mask_if mask_ch();

	cell_balance_top_n_select #(
		.NUM_CELLS (NUM_CELLS),
		.MAX_SELECT(MAX_SEL)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cell_in (cell_ch),
		.mask_out(mask_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// stimulus and expectations
	cell_item_t   cell_queue[$];
	mask_result_t mask_expected[$];

	// shadow of the register file and of the selector state
	cbs_cfg_t            cfg_shadow;
	logic [PERIOD_W-1:0] sleep_period;
	logic [VOLT_W-1:0]   top_volt [MAX_SEL];
	logic [IDX_W-1:0]    top_cell [MAX_SEL];
	logic [VOLT_W-1:0]   scan_min;
	int unsigned         cells_in_scan;

	// handshake flags, set at the rising edge and used by the drivers at the falling edge
	bit cell_taken;
	bit mask_taken;
	bit calm;
	int gap_left;
	int stall_left;
	int idle_cycles;

	int fail_count;
	int items_queued;
	int cells_seen;
	int scans_closed;
	int masks_checked;
	int evals_seen;
	int forced_seen;
	int settings_used;

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	// every scan close starts a fresh candidate list and minimum
	function automatic void restart_scan();
		for (int j = 0; j < MAX_SEL; j++) begin
			top_volt[j] = '0;
			top_cell[j] = '0;
		end
		scan_min      = '1;
		cells_in_scan = 0;
	endfunction

	// sorted insertion into the top-n list, ties keep the earlier cell ahead
	function automatic void rank_cell(input logic [VOLT_W-1:0] v);
		int filled;
		int slot;
		int cap;
		if (cells_in_scan >= NUM_CELLS)
			return;
		if (v < scan_min)
			scan_min = v;
		filled = (cells_in_scan < MAX_SEL) ? cells_in_scan : MAX_SEL;
		slot   = filled;
		// walking downwards leaves the lowest slot that v beats
		for (int j = filled - 1; j >= 0; j--)
			if (v > top_volt[j])
				slot = j;
		if (slot < MAX_SEL) begin
			cap = (filled < MAX_SEL) ? filled : MAX_SEL - 1;
			for (int j = MAX_SEL - 1; j > 0; j--)
				if (j <= cap && j > slot) begin
					top_volt[j] = top_volt[j-1];
					top_cell[j] = top_cell[j-1];
				end
			top_volt[slot] = v;
			top_cell[slot] = IDX_W'(cells_in_scan);
		end
		cells_in_scan++;
	endfunction

	// works out the mask, if any, that one accepted cell transfer causes
	function automatic void predict_cell(input cell_item_t it);
		int                n;
		int                filled;
		logic [31:0]       excess;
		mask_result_t      res;
		rank_cell(it.volt);
		if (!it.last)
			return;
		scans_closed++;
		if (!it.sleep) begin
			// awake: all off, period counter holds
			res.mask       = '0;
			res.forced_off = 1'b1;
			mask_expected.push_back(res);
		end else begin
			if (sleep_period == cfg_shadow.eval_interval) begin
				sleep_period = '0;
				n = (cfg_shadow.cells_to_balance > MAX_SEL) ? MAX_SEL
					: int'(cfg_shadow.cells_to_balance);
				filled = (cells_in_scan < MAX_SEL) ? cells_in_scan : MAX_SEL;
				if (n > filled)
					n = filled;
				// zero candidates still uses up the evaluation slot, but sends nothing
				if (cfg_shadow.cells_to_balance != '0) begin
					res.mask       = '0;
					res.forced_off = 1'b0;
					for (int j = 0; j < MAX_SEL; j++)
						if (j < n) begin
							excess = 32'(top_volt[j]) - 32'(scan_min);
							if (excess > 32'(cfg_shadow.diff_threshold) &&
								scan_min >= cfg_shadow.min_cell_floor &&
								top_cell[j] < MASK_W)
								res.mask[top_cell[j][MBIT_W-1:0]] = 1'b1;
						end
					mask_expected.push_back(res);
				end
			end
			sleep_period = sleep_period + 1'b1;
		end
		restart_scan();
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: results are checked before the cell of the same edge is predicted,
	// since no cell can turn into a mask within its own transfer cycle
	always @(posedge clk) begin
		mask_result_t got;
		mask_result_t want;
		cell_taken = 1'b0;
		mask_taken = 1'b0;
		if (arst_n) begin
			cell_taken = cell_ch.valid && cell_ch.ready;
			mask_taken = mask_ch.valid && mask_ch.ready;
			if (mask_taken) begin
				got.mask       = mask_ch.balance_mask;
				got.forced_off = mask_ch.forced_off;
				masks_checked++;
				if (mask_expected.size() == 0) begin
					$error("unexpected mask transfer: balance_mask %h forced_off %b",
						got.mask, got.forced_off);
					fail_count++;
				end else begin
					want = mask_expected.pop_front();
					if (want.forced_off)
						forced_seen++;
					else
						evals_seen++;
					if (got.mask !== want.mask) begin
						$error("balance_mask expected %h actual %h", want.mask, got.mask);
						fail_count++;
					end
					if (got.forced_off !== want.forced_off) begin
						$error("forced_off expected %b actual %b",
							want.forced_off, got.forced_off);
						fail_count++;
					end
				end
			end
			if (cell_taken) begin
				cells_seen++;
				predict_cell('{volt: cell_ch.cell_voltage, last: cell_ch.last_cell,
					sleep: cell_ch.sleep_mode});
			end
			// watchdog on transfer-free stretches
			if (cell_taken || mask_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no transfer for %0d cycles, %0d masks outstanding",
					idle_cycles, mask_expected.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// cell driver: holds an item until its transfer, then waits its drawn gap
	always @(negedge clk) begin
		cell_item_t nxt;
		if (arst_n && (!cell_ch.valid || cell_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				cell_ch.valid <= 1'b0;
			end else if (cell_queue.size() != 0) begin
				nxt = cell_queue.pop_front();
				cell_ch.valid        <= 1'b1;
				cell_ch.cell_voltage <= nxt.volt;
				cell_ch.last_cell    <= nxt.last;
				cell_ch.sleep_mode   <= nxt.sleep;
				gap_left = draw_wait();
			end else begin
				cell_ch.valid <= 1'b0;
			end
		end
	end

	// mask receiver: a fresh stall, possibly empty, drawn after every transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (mask_taken)
				stall_left = draw_wait();
			if (stall_left != 0) begin
				mask_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				mask_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DIFF_THR:  cfg_shadow.diff_threshold   = val[VOLT_W-1:0];
			REG_MIN_FLOOR: cfg_shadow.min_cell_floor   = val[VOLT_W-1:0];
			REG_CELLS_BAL: cfg_shadow.cells_to_balance = val[CTB_W-1:0];
			REG_INTERVAL:  cfg_shadow.eval_interval    = val[PERIOD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic read_reg(input logic [1:0] idx);
		logic [APB_DATA_W-1:0] want;
		want = '0;
		case (idx)
			REG_DIFF_THR:  want = APB_DATA_W'(cfg_shadow.diff_threshold);
			REG_MIN_FLOOR: want = APB_DATA_W'(cfg_shadow.min_cell_floor);
			REG_CELLS_BAL: want = APB_DATA_W'(cfg_shadow.cells_to_balance);
			REG_INTERVAL:  want = APB_DATA_W'(cfg_shadow.eval_interval);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= CFG_ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata of register %0d expected %h actual %h", idx, want, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_all_regs();
		read_reg(REG_DIFF_THR);
		read_reg(REG_MIN_FLOOR);
		read_reg(REG_CELLS_BAL);
		read_reg(REG_INTERVAL);
	endtask

	task automatic set_config(input logic [VOLT_W-1:0] thr, input logic [VOLT_W-1:0] floor,
		input logic [CTB_W-1:0] ctb, input logic [PERIOD_W-1:0] ivl);
		write_reg(REG_DIFF_THR, APB_DATA_W'(thr));
		write_reg(REG_MIN_FLOOR, APB_DATA_W'(floor));
		write_reg(REG_CELLS_BAL, APB_DATA_W'(ctb));
		write_reg(REG_INTERVAL, APB_DATA_W'(ivl));
		read_all_regs();
		settings_used++;
	endtask

	// block idle: no cell pending, every mask back, then time for a trailing evaluation
	task automatic drain();
		while (cell_queue.size() != 0 || cell_ch.valid || mask_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_cell(input logic [VOLT_W-1:0] v, input logic last,
		input logic sleep);
		cell_item_t it;
		it.volt  = v;
		it.last  = last;
		it.sleep = sleep;
		cell_queue.push_back(it);
		items_queued++;
	endfunction

	// one scan of len cells; sleep_mode on inner cells is noise the block must ignore
	function automatic void push_scan(input int len, input logic asleep,
		input volt_style_e style);
		logic [VOLT_W-1:0] base;
		logic [VOLT_W-1:0] v;
		base = VOLT_W'($urandom_range(2900, 4200));
		for (int c = 0; c < len; c++) begin
			case (style)
				VOLT_SPREAD:  v = VOLT_W'($urandom_range(0, 65535));
				VOLT_CLUSTER: v = base + VOLT_W'($urandom_range(0, 60));
				VOLT_TIES:    v = base + VOLT_W'(25 * $urandom_range(0, 1));
				default: begin
					case ($urandom_range(0, 2))
						0:       v = '0;
						1:       v = '1;
						default: v = VOLT_W'($urandom_range(0, 65535));
					endcase
				end
			endcase
			push_cell(v, c == len - 1, (c == len - 1) ? asleep : 1'($urandom_range(0, 1)));
		end
	endfunction

	initial begin
		int len;
		int phase_start;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		cell_ch.valid        = 1'b0;
		cell_ch.cell_voltage = '0;
		cell_ch.last_cell    = 1'b0;
		cell_ch.sleep_mode   = 1'b0;
		mask_ch.ready        = 1'b0;
		cfg_shadow.diff_threshold   = RST_DIFF_THR;
		cfg_shadow.min_cell_floor   = RST_MIN_FLOOR;
		cfg_shadow.cells_to_balance = RST_CELLS_BAL;
		cfg_shadow.eval_interval    = RST_INTERVAL;
		sleep_period = '0;
		restart_scan();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values of the register file
		read_all_regs();
		settings_used = 1;

		// awake scan with both voltage extremes and sleep noise on an inner cell
		push_cell(16'd0, 1'b0, 1'b1);
		push_cell(16'hFFFF, 1'b0, 1'b0);
		push_cell(16'd3000, 1'b1, 1'b0);
		// single-cell awake scan
		push_cell(16'hFFFF, 1'b1, 1'b0);
		// five sleeping scans that only step the period counter up to the interval
		for (int s = 0; s < 5; s++)
			push_cell(VOLT_W'($urandom_range(0, 65535)), 1'b1, 1'b1);
		// evaluating scan: tied top pair, the lower index ranks first
		push_cell(16'd4000, 1'b0, 1'b1);
		push_cell(16'd5000, 1'b0, 1'b0);
		push_cell(16'd5000, 1'b0, 1'b1);
		push_cell(16'd3990, 1'b1, 1'b1);
		// long awake scan past the cell count
		for (int c = 0; c < NUM_CELLS + 2; c++)
			push_cell(VOLT_W'($urandom_range(0, 65535)), c == NUM_CELLS + 1, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			calm = (p % 3 == 2);
			// extremes first, then random settings
			case (p)
				0: set_config(16'd0, 16'd0, 3'd4, 4'd1);
				1: set_config(16'hFFFF, 16'hFFFF, 3'd7, 4'd15);
				2: set_config(16'd20, 16'd3000, 3'd0, 4'd2);
				3: set_config(VOLT_W'($urandom_range(0, 60)), VOLT_W'($urandom_range(0, 3500)),
					3'd5, 4'd0);
				default: set_config(VOLT_W'($urandom_range(0, 60)),
					VOLT_W'($urandom_range(0, 4500)), CTB_W'($urandom_range(0, 7)),
					PERIOD_W'($urandom_range(1, 15)));
			endcase
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0:       len = $urandom_range(1, 3);
					1:       len = $urandom_range(NUM_CELLS + 1, NUM_CELLS + 6);
					default: len = $urandom_range(4, NUM_CELLS);
				endcase
				push_scan(len, $urandom_range(0, 9) < 7, volt_style_e'($urandom_range(0, 3)));
			end
		end

		drain();
		if (mask_expected.size() != 0) begin
			$error("balance_mask: %0d expected results never arrived", mask_expected.size());
			fail_count++;
		end
		$display("covered %0d cells in %0d scans across %0d register settings",
			cells_seen, scans_closed, settings_used);
		$display("checked %0d masks: %0d evaluated, %0d forced off, %0d mismatches",
			masks_checked, evals_seen, forced_seen, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cbs_pkg.sv
rtl/cbs_if.sv
rtl/cbs_regs.sv
rtl/cbs_topn.sv
rtl/cbs_eval.sv
rtl/cell_balance_top_n_select.sv
verif/tb_cell_balance_top_n_select.sv
